@@ hdl/srt_pkg.sv @@
`default_nettype none

package srt_pkg;

	// Table geometry.
	localparam int CAPACITY = 128;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Field widths.
	localparam int KEY_W  = 16;
	localparam int QTY_W  = 16;
	localparam int COST_W = 24;
	localparam int POS_W  = 7;
	localparam int OCC_W  = 8;

	// Command codes. The last code is not used and is rejected.
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Status codes.
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;
	localparam logic [1:0] STAT_INVALID   = 2'd3;

	// One stored record.
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [QTY_W-1:0]  quantity;
		logic [COST_W-1:0] cost;
	} srt_rec_t;

endpackage

`default_nettype wire

@@ hdl/sorted_record_table.sv @@
// An insert goes through accept, scan to the insertion point, shift of the tail, write
// and finish; a lookup scans to the match, a delete that finds its key also shifts the
// tail down, and a rejected key or a full table goes from accept straight to finish.
// One item at a time; the record memory, one read and one write per cycle, sets the pace.
// The result waits in an output register, so a stalled result blocks only the next finish.
// Reset clears the record count and all control state; record contents are not cleared.
`default_nettype none

module sorted_record_table (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    cmd,
	input  wire logic [srt_pkg::KEY_W-1:0]     key,
	input  wire logic [srt_pkg::QTY_W-1:0]     quantity,
	input  wire logic [srt_pkg::COST_W-1:0]    cost,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [1:0]                         status,
	output logic [srt_pkg::KEY_W-1:0]          found_key,
	output logic [srt_pkg::QTY_W-1:0]          found_quantity,
	output logic [srt_pkg::COST_W-1:0]         found_cost,
	output logic [srt_pkg::POS_W-1:0]          position,
	output logic [srt_pkg::OCC_W-1:0]          occupancy
);
	import srt_pkg::*;

	// Sequencer states.
	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_SCAN      = 3'd1;
	localparam logic [2:0] S_SHIFT_UP  = 3'd2;
	localparam logic [2:0] S_WRITE_NEW = 3'd3;
	localparam logic [2:0] S_SHIFT_DN  = 3'd4;
	localparam logic [2:0] S_FINISH    = 3'd5;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] p_q;
	logic             pend_q;
	logic [IDX_W-1:0] pidx_q;

	logic [1:0]       cmd_q;
	srt_rec_t         new_q;

	logic [1:0]       res_status_q;
	srt_rec_t         res_rec_q;
	logic [POS_W-1:0] res_pos_q;

	logic             out_valid_q;
	logic [1:0]       out_status_q;
	srt_rec_t         out_rec_q;
	logic [POS_W-1:0] out_pos_q;
	logic [OCC_W-1:0] out_occ_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	srt_rec_t         ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	srt_rec_t         ram_rdata;

	logic             hit;
	logic             key_eq;
	logic [CNT_W-1:0] ptr_dec;

	srt_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_stall = (state_q != S_IDLE);
	assign ptr_dec  = ptr_q - CNT_W'(1);

	// Shared compare unit: an insert stops at the first larger key, the others at the
	// first key that is not smaller.
	assign key_eq = (ram_rdata.key == new_q.key);
	assign hit    = pend_q && ((cmd_q == CMD_INSERT) ? (ram_rdata.key > new_q.key)
	                                                 : (ram_rdata.key >= new_q.key));

	// Memory address and write selection.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pidx_q;
		ram_wdata = ram_rdata;
		ram_raddr = ptr_q[IDX_W-1:0];
		unique case (state_q)
			S_SHIFT_UP: begin
				ram_we    = pend_q;
				ram_raddr = ptr_dec[IDX_W-1:0];
			end
			S_SHIFT_DN: begin
				ram_we = pend_q;
			end
			S_WRITE_NEW: begin
				ram_we    = 1'b1;
				ram_waddr = p_q[IDX_W-1:0];
				ram_wdata = new_q;
			end
			default: begin
			end
		endcase
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					pend_q <= 1'b0;
					if (in_valid) begin
						if (cmd == CMD_UNUSED || key == '0) begin
							state_q <= S_FINISH;
						end else if (cmd == CMD_INSERT && fill_q == CNT_W'(CAPACITY)) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						pend_q <= 1'b0;
						if (cmd_q == CMD_INSERT) begin
							state_q <= S_SHIFT_UP;
						end else if (!key_eq || cmd_q == CMD_LOOKUP) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_SHIFT_DN;
						end
					end else if (!pend_q && ptr_q == fill_q) begin
						state_q <= (cmd_q == CMD_INSERT) ? S_SHIFT_UP : S_FINISH;
					end else begin
						pend_q <= (ptr_q < fill_q);
					end
				end
				S_SHIFT_UP: begin
					if (ptr_q > p_q) begin
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= S_WRITE_NEW;
						end
					end
				end
				S_WRITE_NEW: begin
					fill_q  <= fill_q + CNT_W'(1);
					state_q <= S_FINISH;
				end
				S_SHIFT_DN: begin
					if (ptr_q < fill_q) begin
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							fill_q  <= fill_q - CNT_W'(1);
							state_q <= S_FINISH;
						end
					end
				end
				S_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers and result payload.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q          <= cmd;
				new_q.key      <= key;
				new_q.quantity <= quantity;
				new_q.cost     <= cost;
				ptr_q          <= '0;
				res_rec_q      <= '0;
				res_pos_q      <= '0;
				if (cmd == CMD_UNUSED || key == '0) begin
					res_status_q <= STAT_INVALID;
				end else if (cmd == CMD_INSERT && fill_q == CNT_W'(CAPACITY)) begin
					res_status_q <= STAT_FULL;
				end else begin
					res_status_q <= STAT_NOT_FOUND;
				end
			end
			S_SCAN: begin
				if (hit) begin
					p_q <= CNT_W'(pidx_q);
					if (cmd_q == CMD_INSERT) begin
						ptr_q <= fill_q;
					end else begin
						ptr_q <= CNT_W'(pidx_q) + CNT_W'(1);
						if (key_eq) begin
							res_status_q <= STAT_OK;
							res_rec_q    <= ram_rdata;
							res_pos_q    <= pidx_q;
						end
					end
				end else if (!pend_q && ptr_q == fill_q) begin
					p_q <= fill_q;
				end else if (ptr_q < fill_q) begin
					pidx_q <= ptr_q[IDX_W-1:0];
					ptr_q  <= ptr_q + CNT_W'(1);
				end
			end
			S_SHIFT_UP: begin
				if (ptr_q > p_q) begin
					pidx_q <= ptr_q[IDX_W-1:0];
					ptr_q  <= ptr_dec;
				end
			end
			S_WRITE_NEW: begin
				res_status_q <= STAT_OK;
				res_rec_q    <= new_q;
				res_pos_q    <= p_q[POS_W-1:0];
			end
			S_SHIFT_DN: begin
				if (ptr_q < fill_q) begin
					pidx_q <= ptr_dec[IDX_W-1:0];
					ptr_q  <= ptr_q + CNT_W'(1);
				end
			end
			S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					out_status_q <= res_status_q;
					out_rec_q    <= res_rec_q;
					out_pos_q    <= res_pos_q;
					out_occ_q    <= OCC_W'(fill_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign found_key      = out_rec_q.key;
	assign found_quantity = out_rec_q.quantity;
	assign found_cost     = out_rec_q.cost;
	assign position       = out_pos_q;
	assign occupancy      = out_occ_q;

	// The record count never passes the capacity.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(CAPACITY))
		else $error("record count above capacity");

	// The record count moves by at most one per command.
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |->
		(fill_q == $past(fill_q) + CNT_W'(1) || fill_q == $past(fill_q) - CNT_W'(1)))
		else $error("record count jumped");

	// The memory is written only while a command is at work.
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_SHIFT_UP || state_q == S_SHIFT_DN ||
		            state_q == S_WRITE_NEW))
		else $error("memory write outside a shift");

	// A failed command reports an empty record at position zero.
	a_fail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != STAT_OK) |->
		(out_rec_q.key == '0 && out_pos_q == '0))
		else $error("failed command carries a record");

endmodule

`default_nettype wire

@@ hdl/srt_ram.sv @@
`default_nettype none

module srt_ram (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [srt_pkg::IDX_W-1:0]    waddr,
	input  wire srt_pkg::srt_rec_t            wdata,
	input  wire logic [srt_pkg::IDX_W-1:0]    raddr,
	output srt_pkg::srt_rec_t                 rdata
);
	import srt_pkg::*;

	srt_rec_t mem_q [CAPACITY];
	srt_rec_t rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ tb/sorted_record_table_checker.sv @@
`default_nettype none

module sorted_record_table_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_stall,
	input  wire logic [1:0]                    cmd,
	input  wire logic [srt_pkg::KEY_W-1:0]     key,
	input  wire logic [srt_pkg::QTY_W-1:0]     quantity,
	input  wire logic [srt_pkg::COST_W-1:0]    cost,
	input  wire logic                          out_valid,
	input  wire logic                          out_stall,
	input  wire logic [1:0]                    status,
	input  wire logic [srt_pkg::KEY_W-1:0]     found_key,
	input  wire logic [srt_pkg::QTY_W-1:0]     found_quantity,
	input  wire logic [srt_pkg::COST_W-1:0]    found_cost,
	input  wire logic [srt_pkg::POS_W-1:0]     position,
	input  wire logic [srt_pkg::OCC_W-1:0]     occupancy,
	output int                                 errors,
	output int                                 replies_pending,
	output int                                 ok_count,
	output int                                 missing_count,
	output int                                 full_count,
	output int                                 rejected_count,
	output int                                 peak_held
);
	timeunit 1ns;
	timeprecision 1ps;
	import srt_pkg::*;

	// One reply of the table, field for field as it leaves the block.
	typedef struct packed {
		logic [1:0]        status;
		logic [KEY_W-1:0]  key;
		logic [QTY_W-1:0]  quantity;
		logic [COST_W-1:0] cost;
		logic [POS_W-1:0]  pos;
		logic [OCC_W-1:0]  occ;
	} reply_t;

	// Private copy of the table contents and its fill level.
	srt_rec_t rows [CAPACITY];
	int       held = 0;

	reply_t   replies_due [$];
	reply_t   seen;
	reply_t   want;
	int       reported = 0;
	int       replies_seen = 0;

	// Apply one command to the private table and return the reply it should give.
	function automatic reply_t table_apply(input logic [1:0] c, input logic [KEY_W-1:0] k,
			input logic [QTY_W-1:0] q, input logic [COST_W-1:0] cs);
		reply_t r;
		int     p;
		int     i;
		r = '0;
		if ((c != CMD_INSERT && c != CMD_DELETE && c != CMD_LOOKUP) || k == '0) begin
			r.status = STAT_INVALID;
		end else if (c == CMD_INSERT) begin
			if (held >= CAPACITY) begin
				r.status = STAT_FULL;
			end else begin
				// The new record goes after every record whose key is not larger.
				p = 0;
				while (p < held && rows[p].key <= k)
					p++;
				for (i = held; i > p; i--)
					rows[i] = rows[i-1];
				rows[p] = '{key: k, quantity: q, cost: cs};
				held++;
				r.status = STAT_OK;
				r.key = k;
				r.quantity = q;
				r.cost = cs;
				r.pos = POS_W'(p);
			end
		end else begin
			// Delete and lookup both act on the first record with this key.
			p = 0;
			while (p < held && rows[p].key != k)
				p++;
			if (p == held) begin
				r.status = STAT_NOT_FOUND;
			end else begin
				r.status = STAT_OK;
				r.key = rows[p].key;
				r.quantity = rows[p].quantity;
				r.cost = rows[p].cost;
				r.pos = POS_W'(p);
				if (c == CMD_DELETE) begin
					for (i = p; i < held - 1; i++)
						rows[i] = rows[i+1];
					held--;
				end
			end
		end
		r.occ = OCC_W'(held);
		return r;
	endfunction

	// Compare each reply transfer with the oldest prediction, then predict for a new command.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			replies_due.delete();
			replies_pending = 0;
			errors = 0;
			ok_count = 0;
			missing_count = 0;
			full_count = 0;
			rejected_count = 0;
			peak_held = 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen = '{status, found_key, found_quantity, found_cost, position, occupancy};
				replies_seen++;
				if (replies_due.size() == 0) begin
					errors++;
					if (reported < 10) begin
						reported++;
						$display("%0t: reply %0d arrived with nothing expected: status %0d key %h",
							$realtime, replies_seen, seen.status, seen.key);
					end
				end else begin
					want = replies_due.pop_front();
					if (seen.status !== want.status || seen.key !== want.key ||
							seen.quantity !== want.quantity || seen.cost !== want.cost ||
							seen.pos !== want.pos || seen.occ !== want.occ) begin
						errors++;
						if (reported < 10) begin
							reported++;
							$display("%0t: reply %0d mismatch", $realtime, replies_seen);
							$display("  expected status %0d key %h qty %h cost %h pos %0d occ %0d",
								want.status, want.key, want.quantity, want.cost, want.pos,
								want.occ);
							$display("  actual   status %0d key %h qty %h cost %h pos %0d occ %0d",
								seen.status, seen.key, seen.quantity, seen.cost, seen.pos,
								seen.occ);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				want = table_apply(cmd, key, quantity, cost);
				replies_due.push_back(want);
				case (want.status)
					STAT_OK:        ok_count++;
					STAT_NOT_FOUND: missing_count++;
					STAT_FULL:      full_count++;
					default:        rejected_count++;
				endcase
				if (held > peak_held)
					peak_held = held;
			end
			replies_pending = replies_due.size();
		end
	end

endmodule

`default_nettype wire

@@ tb/sorted_record_table_tb.sv @@
`default_nettype none

module sorted_record_table_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import srt_pkg::*;

	localparam int RANDOM_ITEMS = 900;
	localparam int CALM_TAIL    = 100;
	localparam int DRAIN_CYCLES = 2 * CAPACITY + 40;
	localparam int CYCLE_LIMIT  = 1_500_000;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [1:0]          cmd = CMD_INSERT;
	logic [KEY_W-1:0]    key = '0;
	logic [QTY_W-1:0]    quantity = '0;
	logic [COST_W-1:0]   cost = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [1:0]          status;
	logic [KEY_W-1:0]    found_key;
	logic [QTY_W-1:0]    found_quantity;
	logic [COST_W-1:0]   found_cost;
	logic [POS_W-1:0]    position;
	logic [OCC_W-1:0]    occupancy;

	int errors;
	int replies_pending;
	int ok_count;
	int missing_count;
	int full_count;
	int rejected_count;
	int peak_held;

	// Idling controls shared by the command and reply sides.
	logic tx_idle = 1'b0;
	logic rx_idle = 1'b0;
	logic calm = 1'b0;
	int   rx_left = 0;
	int   cycles = 0;
	int   sent = 0;

	sorted_record_table dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.key            (key),
		.quantity       (quantity),
		.cost           (cost),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.found_key      (found_key),
		.found_quantity (found_quantity),
		.found_cost     (found_cost),
		.position       (position),
		.occupancy      (occupancy)
	);

	sorted_record_table_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.cmd             (cmd),
		.key             (key),
		.quantity        (quantity),
		.cost            (cost),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.found_key       (found_key),
		.found_quantity  (found_quantity),
		.found_cost      (found_cost),
		.position        (position),
		.occupancy       (occupancy),
		.errors          (errors),
		.replies_pending (replies_pending),
		.ok_count        (ok_count),
		.missing_count   (missing_count),
		.full_count      (full_count),
		.rejected_count  (rejected_count),
		.peak_held       (peak_held)
	);

	// Clock with a 12 ns period.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Give up if the run takes far longer than the slowest correct one.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("sorted_record_table_tb: done, errors");
			$finish;
		end
	end

	// The reply side stalls in bursts of random length while idling is enabled.
	always @(negedge clk) begin
		if (!calm && rx_left > 0) begin
			rx_left <= rx_left - 1;
			out_stall <= 1'b1;
		end else if (rx_idle && !calm && $urandom_range(0, 5) == 0) begin
			rx_left <= $urandom_range(0, 16);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Present one command at a falling edge and hold it until its transfer.
	task automatic send_command(input logic [1:0] c, input logic [KEY_W-1:0] k,
			input logic [QTY_W-1:0] q, input logic [COST_W-1:0] cs);
		int gap;
		if (tx_idle && !calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 17);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd <= c;
		key <= k;
		quantity <= q;
		cost <= cs;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	initial begin
		int               random_sent;
		int               phase;
		int               phase_len;
		int               w_insert;
		int               w_delete;
		int               pool_max;
		int               roll;
		logic [1:0]       c;
		logic [KEY_W-1:0] k;
		logic [QTY_W-1:0] q;
		logic [COST_W-1:0] cs;

		random_sent = 0;
		phase = 0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: empty table, rejected keys, the unused command, extremes and
		// duplicate keys, then deletes at both ends, and inserts either side of the key midpoint.
		send_command(CMD_LOOKUP, 16'd5, 16'h0000, 24'h000000);
		send_command(CMD_DELETE, 16'd5, 16'h0000, 24'h000000);
		send_command(CMD_INSERT, 16'd0, 16'h1234, 24'h123456);
		send_command(CMD_DELETE, 16'd0, 16'h0000, 24'h000000);
		send_command(CMD_LOOKUP, 16'd0, 16'h0000, 24'h000000);
		send_command(CMD_UNUSED, 16'd7, 16'hffff, 24'hffffff);
		send_command(CMD_INSERT, 16'hffff, 16'hffff, 24'hffffff);
		send_command(CMD_INSERT, 16'd1, 16'h0000, 24'h000000);
		send_command(CMD_INSERT, 16'd300, 16'd1234, 24'd5000);
		send_command(CMD_INSERT, 16'd300, 16'd2, 24'd7);
		send_command(CMD_INSERT, 16'd300, 16'd3, 24'd9);
		send_command(CMD_LOOKUP, 16'd300, 16'h0000, 24'h000000);
		send_command(CMD_DELETE, 16'd300, 16'h0000, 24'h000000);
		send_command(CMD_LOOKUP, 16'd300, 16'h0000, 24'h000000);
		send_command(CMD_DELETE, 16'd301, 16'h0000, 24'h000000);
		send_command(CMD_LOOKUP, 16'hffff, 16'h0000, 24'h000000);
		send_command(CMD_DELETE, 16'd1, 16'h0000, 24'h000000);
		send_command(CMD_DELETE, 16'hffff, 16'h0000, 24'h000000);
		send_command(CMD_INSERT, 16'h8000, 16'h5555, 24'haaaaaa);
		send_command(CMD_INSERT, 16'h7fff, 16'haaaa, 24'h555555);
		send_command(CMD_UNUSED, 16'd0, 16'h0000, 24'h000000);
		send_command(CMD_LOOKUP, 16'h7fff, 16'h0000, 24'h000000);

		// Random part in phases: the first fills the table past full, the second
		// drains it, the rest mix the commands with varied key pools.
		while (random_sent < RANDOM_ITEMS) begin
			if (phase == 0) begin
				phase_len = 220;
				w_insert = 88;
				w_delete = 4;
				pool_max = 40;
			end else if (phase == 1) begin
				phase_len = 180;
				w_insert = 10;
				w_delete = 70;
				pool_max = 40;
			end else begin
				phase_len = $urandom_range(40, 140);
				w_insert = $urandom_range(15, 70);
				w_delete = $urandom_range(10, 90 - w_insert);
				case ($urandom_range(0, 2))
					0:       pool_max = 4;
					1:       pool_max = 32;
					default: pool_max = 400;
				endcase
			end
			tx_idle = ($urandom_range(0, 2) != 0);
			rx_idle = ($urandom_range(0, 2) != 0);
			phase++;

			repeat (phase_len) begin
				if (random_sent >= RANDOM_ITEMS)
					break;
				calm = (RANDOM_ITEMS - random_sent <= CALM_TAIL);

				roll = $urandom_range(0, 99);
				if (roll < 3)
					c = CMD_UNUSED;
				else if (roll < 3 + w_insert)
					c = CMD_INSERT;
				else if (roll < 3 + w_insert + w_delete)
					c = CMD_DELETE;
				else
					c = CMD_LOOKUP;

				roll = $urandom_range(0, 99);
				if (roll < 3)
					k = '0;
				else if (roll < 8)
					k = ($urandom_range(0, 1) == 0) ? 16'd1 : 16'hffff;
				else if (roll < 18)
					k = KEY_W'($urandom_range(1, 65535));
				else
					k = KEY_W'($urandom_range(1, pool_max));

				roll = $urandom_range(0, 9);
				q = (roll == 0) ? '0 : (roll == 1) ? '1 : QTY_W'($urandom);
				roll = $urandom_range(0, 9);
				cs = (roll == 0) ? '0 : (roll == 1) ? '1 : COST_W'($urandom);

				send_command(c, k, q, cs);
				random_sent++;
			end
		end
		in_valid <= 1'b0;

		// Wait for every reply, then a little longer for anything stray.
		while (replies_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sorted_record_table_tb: %0d commands: %0d ok, %0d missing key, %0d table full,",
			sent, ok_count, missing_count, full_count);
		$display("sorted_record_table_tb: %0d rejected; peak occupancy %0d, %0d mismatches",
			rejected_count, peak_held, errors);
		if (errors == 0)
			$display("sorted_record_table_tb: done, clean");
		else
			$display("sorted_record_table_tb: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
hdl/srt_pkg.sv
hdl/srt_ram.sv
hdl/sorted_record_table.sv
tb/sorted_record_table_checker.sv
tb/sorted_record_table_tb.sv
